// ----- design/skmc_pkg.sv -----
// Shared types and constants for the smoothed knob to MIDI control change block.
// No dependencies; used by skmc_smoother, skmc_tx and smoothed_knob_to_midi_cc.
package skmc_pkg;

    // Field widths
    localparam int KNOB_W   = 2;
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 16;   // Q12.4 smoothed level
    localparam int VALUE_W  = 7;    // MIDI data byte payload
    localparam int CHAN_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int S_TDATA_W = 16;  // knob_index, sample, host_ready, padded to bytes

    localparam int NUM_KNOBS_DEF = 3;

    // Full scale of the level in Q12.4 (4095 * 16)
    localparam logic [LEVEL_W-1:0] FULL_SCALE_Q4 = LEVEL_W'(4095 * 16);

    // Control change status byte, channel goes in the low nibble
    localparam logic [BYTE_W-1:0] STATUS_CC = 8'hB0;

    // Configuration register indexes
    typedef enum logic
    {
        CFG_MIDI_CHANNEL    = 1'b0,
        CFG_CONTROLLER_BASE = 1'b1
    } cfg_reg_t;

    // Smoother result for the item at the input register
    typedef struct packed
    {
        logic               in_range;
        logic               changed;
        logic [VALUE_W-1:0] value;
    } smooth_res_t;

    // One complete control change message
    typedef struct packed
    {
        logic [BYTE_W-1:0]  status;
        logic [VALUE_W-1:0] controller;
        logic [VALUE_W-1:0] value;
    } cc_msg_t;

endpackage

// ----- design/smoothed_knob_to_midi_cc.sv -----
// Top level: input register, config registers, smoother and control change serializer.
// Depends on skmc_pkg, skmc_smoother and skmc_tx.
//
//  channel   dir  handshake                      content
//  s_axis    in   s_axis_tvalid/s_axis_tready    one knob sample per beat
//  m_axis    out  m_axis_tvalid/m_axis_tready    one MIDI byte per beat, tlast on third
//  cfg       in   cfg_we (no wait)               midi_channel, controller_base
//
// A sample is registered, then smoothed and compared in the next cycle; a sample
// that causes no message retires without stalling. A message holds the output register
// for three beats; the next message can load as the last beat of the previous one is taken.
// A sample that causes a message waits in the input register while the previous
// message is still going out. Reset clears all smoothing state and the MIDI channel, and sets the controller base to 1.
module smoothed_knob_to_midi_cc #(
    parameter int NUM_KNOBS = skmc_pkg::NUM_KNOBS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [skmc_pkg::S_TDATA_W-1:0] s_axis_tdata,  // knob_index[1:0], sample[13:2],
                                                          // host_ready[14], zero[15]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [skmc_pkg::BYTE_W-1:0]    m_axis_tdata,  // out_byte[7:0]
    output logic                           m_axis_tlast,  // last_byte
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [skmc_pkg::VALUE_W-1:0]   cfg_wdata
);

    localparam int SAMPLE_LO = skmc_pkg::KNOB_W;
    localparam int SAMPLE_HI = skmc_pkg::KNOB_W + skmc_pkg::SAMPLE_W - 1;
    localparam int READY_BIT = SAMPLE_HI + 1;

    logic                          in_valid_reg;
    logic [skmc_pkg::KNOB_W-1:0]   in_knob_reg;
    logic [skmc_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic                          in_host_reg;

    logic [skmc_pkg::CHAN_W-1:0]   midi_channel_reg;
    logic [skmc_pkg::VALUE_W-1:0]  controller_base_reg;

    skmc_pkg::smooth_res_t res;
    skmc_pkg::cc_msg_t     msg;
    logic                  can_load;
    logic                  emit;
    logic                  advance;
    logic                  in_fire;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midi_channel_reg    <= '0;
            controller_base_reg <= 7'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                skmc_pkg::CFG_MIDI_CHANNEL:
                    midi_channel_reg <= cfg_wdata[skmc_pkg::CHAN_W-1:0];
                skmc_pkg::CFG_CONTROLLER_BASE:
                    controller_base_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input stage handshake
    assign emit    = in_valid_reg && res.in_range && res.changed && in_host_reg;
    assign advance = in_valid_reg && (!emit || can_load);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_knob_reg   <= s_axis_tdata[skmc_pkg::KNOB_W-1:0];
            in_sample_reg <= s_axis_tdata[SAMPLE_HI:SAMPLE_LO];
            in_host_reg   <= s_axis_tdata[READY_BIT];
        end
    end

    skmc_smoother #(
        .NUM_KNOBS (NUM_KNOBS)
    ) u_smoother (
        .clk        (clk),
        .rst_n      (rst_n),
        .knob_index (in_knob_reg),
        .sample     (in_sample_reg),
        .update     (advance),
        .res        (res)
    );

    // Build the message
    assign msg.status     = skmc_pkg::STATUS_CC | {4'b0000, midi_channel_reg};
    assign msg.controller = controller_base_reg + skmc_pkg::VALUE_W'(in_knob_reg);
    assign msg.value      = res.value;

    skmc_tx u_tx (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && emit),
        .msg           (msg),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A sample blocked behind a message is held unchanged
    a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_sample_reg)
                                     && $stable(in_knob_reg))
        else $error("blocked sample lost or changed");

endmodule

// ----- design/skmc_smoother.sv -----
// Per-knob exponential moving average and 0..127 scaling.
// Depends on skmc_pkg.
module skmc_smoother #(
    parameter int NUM_KNOBS = skmc_pkg::NUM_KNOBS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [skmc_pkg::KNOB_W-1:0]   knob_index,
    input  logic [skmc_pkg::SAMPLE_W-1:0] sample,
    input  logic                          update,
    output skmc_pkg::smooth_res_t         res
);

    logic [skmc_pkg::LEVEL_W-1:0] level_reg [NUM_KNOBS];
    logic [skmc_pkg::VALUE_W-1:0] prev_reg  [NUM_KNOBS];

    logic [skmc_pkg::LEVEL_W-1:0]   sel_level;
    logic [skmc_pkg::VALUE_W-1:0]   sel_prev;
    logic                           in_range;
    logic [skmc_pkg::LEVEL_W+1:0]   level_x3;
    logic [skmc_pkg::LEVEL_W:0]     level_sum;
    logic [skmc_pkg::LEVEL_W-1:0]   level_next;
    logic [skmc_pkg::LEVEL_W+6:0]   scaled;
    logic [skmc_pkg::VALUE_W-1:0]   quot;
    logic [skmc_pkg::LEVEL_W:0]     rem;
    logic [skmc_pkg::VALUE_W-1:0]   value;

    // Select this knob's state
    always_comb
    begin
        sel_level = '0;
        sel_prev  = '0;
        in_range  = 1'b0;
        for (int k = 0; k < NUM_KNOBS; k++)
        begin
            if (32'(knob_index) == k)
            begin
                in_range  = 1'b1;
                sel_level = level_reg[k];
                sel_prev  = prev_reg[k];
            end
        end
    end

    // level' = sample*4 + floor(3*level/4)
    assign level_x3   = {1'b0, sel_level, 1'b0} + {2'b00, sel_level};
    assign level_sum  = (skmc_pkg::LEVEL_W+1)'({sample, 2'b00})
                      + (skmc_pkg::LEVEL_W+1)'(level_x3[skmc_pkg::LEVEL_W+1:2]);
    assign level_next = level_sum[skmc_pkg::LEVEL_W-1:0];

    // value = floor(level*127 / 65520): take level*127 >> 16, then one correction step
    assign scaled = {level_next, 7'b0} - (skmc_pkg::LEVEL_W+7)'(level_next);
    assign quot   = scaled[skmc_pkg::LEVEL_W+6:skmc_pkg::LEVEL_W];
    assign rem    = {1'b0, scaled[skmc_pkg::LEVEL_W-1:0]}
                  + (skmc_pkg::LEVEL_W+1)'({quot, 4'b0000});
    assign value  = (rem >= {1'b0, skmc_pkg::FULL_SCALE_Q4}) ? quot + 7'd1 : quot;

    assign res.in_range = in_range;
    assign res.changed  = (value != sel_prev);
    assign res.value    = value;

    // State update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KNOBS; k++)
            begin
                level_reg[k] <= '0;
                prev_reg[k]  <= '0;
            end
        end
        else if (update)
        begin
            for (int k = 0; k < NUM_KNOBS; k++)
            begin
                if (32'(knob_index) == k)
                begin
                    level_reg[k] <= level_next;
                    prev_reg[k]  <= value;
                end
            end
        end
    end

endmodule

// ----- design/skmc_tx.sv -----
// Message register and byte serializer for control change output beats.
// Depends on skmc_pkg.
module skmc_tx (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  skmc_pkg::cc_msg_t           msg,
    output logic                        can_load,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [skmc_pkg::BYTE_W-1:0] m_axis_tdata,   // out_byte
    output logic                        m_axis_tlast    // last_byte
);

    typedef enum logic [2:0]
    {
        BEAT_STATUS = 3'b001,
        BEAT_CTRL   = 3'b010,
        BEAT_VALUE  = 3'b100
    } beat_t;

    beat_t             beat_reg;
    logic              msg_valid_reg;
    skmc_pkg::cc_msg_t msg_reg;

    logic fire;
    logic done;

    assign fire     = msg_valid_reg && m_axis_tready;
    assign done     = fire && (beat_reg == BEAT_VALUE);
    assign can_load = !msg_valid_reg || done;

    // Message holding and beat sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid_reg <= 1'b0;
            beat_reg      <= BEAT_STATUS;
        end
        else if (load)
        begin
            msg_valid_reg <= 1'b1;
            beat_reg      <= BEAT_STATUS;
        end
        else if (done)
        begin
            msg_valid_reg <= 1'b0;
            beat_reg      <= BEAT_STATUS;
        end
        else if (fire)
        begin
            case (beat_reg)
                BEAT_STATUS: beat_reg <= BEAT_CTRL;
                BEAT_CTRL:   beat_reg <= BEAT_VALUE;
                default:     beat_reg <= BEAT_STATUS;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            msg_reg <= msg;
        end
    end

    // Output byte select
    always_comb
    begin
        case (beat_reg)
            BEAT_STATUS: m_axis_tdata = msg_reg.status;
            BEAT_CTRL:   m_axis_tdata = {1'b0, msg_reg.controller};
            BEAT_VALUE:  m_axis_tdata = {1'b0, msg_reg.value};
            default:     m_axis_tdata = '0;
        endcase
    end

    assign m_axis_tvalid = msg_valid_reg;
    assign m_axis_tlast  = (beat_reg == BEAT_VALUE);

    // A new message never overwrites one still being sent
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("message loaded while previous one in flight");

    // A message always starts with the status byte
    a_start_status: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(msg_valid_reg) |-> beat_reg == BEAT_STATUS)
        else $error("message started on a non-status beat");

    // A message is never cut short after a non-final beat
    a_no_cut: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !m_axis_tlast |=> msg_valid_reg)
        else $error("message dropped before its last byte");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for smoothed_knob_to_midi_cc: drives knob samples and register
// writes, predicts the control change bytes, and checks every output beat.
// Depends on skmc_pkg and the smoothed_knob_to_midi_cc RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int NUM_KNOBS = 3;

    // One stimulus row; typed rows carry their expected message inline
    typedef struct packed
    {
        logic [1:0]  knob;
        logic [11:0] smp;
        logic        rdy;
        logic        typed;
        logic [1:0]  n_exp;
        logic [7:0]  st;
        logic [6:0]  ctl;
        logic [6:0]  val;
    } sample_row_t;

    // One output beat
    typedef struct packed
    {
        logic [7:0] data;
        logic       last;
    } midi_beat_t;

    // Directed rows, run under the reset register values
    localparam sample_row_t DIRECTED_ROWS [24] = '{
        '{2'd0, 12'd4095, 1'b1, 1'b1, 2'd3, 8'hB0, 7'd1, 7'd31},  // first full-scale hit
        '{2'd3, 12'd4095, 1'b1, 1'b1, 2'd0, 8'h00, 7'd0, 7'd0},   // knob out of range
        '{2'd1, 12'd0,    1'b1, 1'b1, 2'd0, 8'h00, 7'd0, 7'd0},   // value unchanged
        '{2'd2, 12'd4095, 1'b0, 1'b1, 2'd0, 8'h00, 7'd0, 7'd0},   // host not ready
        '{2'd2, 12'd4095, 1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd0, 12'd4095, 1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},   // climb toward 127
        '{2'd0, 12'd4095, 1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd0, 12'd4095, 1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd0, 12'd4095, 1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd0, 12'd4095, 1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd0, 12'd4095, 1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd0, 12'd4095, 1'b0, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd3, 12'd0,    1'b0, 1'b1, 2'd0, 8'h00, 7'd0, 7'd0},   // knob out of range
        '{2'd1, 12'd1,    1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd1, 12'd2048, 1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd0, 12'd0,    1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},   // decay from the top
        '{2'd0, 12'd0,    1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd0, 12'd0,    1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd0, 12'd0,    1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd2, 12'd0,    1'b0, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd1, 12'd4095, 1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd3, 12'd2730, 1'b1, 1'b1, 2'd0, 8'h00, 7'd0, 7'd0},   // out of range, odd bits
        '{2'd1, 12'd1365, 1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0},
        '{2'd2, 12'd4095, 1'b1, 1'b0, 2'd0, 8'h00, 7'd0, 7'd0}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    // knob_index[1:0], sample[13:2], host_ready[14]
    logic [skmc_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [skmc_pkg::BYTE_W-1:0]    m_axis_tdata;   // out_byte[7:0]
    logic                           m_axis_tlast;
    logic                           cfg_we;
    skmc_pkg::cfg_reg_t             cfg_index;
    logic [skmc_pkg::VALUE_W-1:0]   cfg_wdata;

    // Predictor state
    logic [15:0] level_mem [NUM_KNOBS];
    logic [6:0]  prev_val [NUM_KNOBS];
    logic [3:0]  chan_reg;
    logic [6:0]  base_reg;
    logic [11:0] last_smp [4];

    midi_beat_t midi_expect_q [$];
    int         errors;
    int         beats_seen;
    bit         steady_flow;

    smoothed_knob_to_midi_cc #(
        .NUM_KNOBS (NUM_KNOBS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Run limit
    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    // Smoothing, scaling and change detection for one sample; returns the beat count
    function automatic int predict_cc(input logic [1:0] knob, input logic [11:0] smp,
                                      input logic rdy, output midi_beat_t msg [3]);
        logic [31:0] lvl;
        logic [6:0]  val;
        msg[0] = '0;
        msg[1] = '0;
        msg[2] = '0;
        if (knob >= NUM_KNOBS)
            return 0;
        lvl = 32'(smp) * 32'd4 + (32'(level_mem[knob]) * 32'd3) / 32'd4;
        level_mem[knob] = lvl[15:0];
        val = 7'((32'(lvl[15:0]) * 32'd127) / 32'(skmc_pkg::FULL_SCALE_Q4));
        if (val == prev_val[knob])
            return 0;
        prev_val[knob] = val;
        if (!rdy)
            return 0;
        msg[0] = '{skmc_pkg::STATUS_CC | {4'd0, chan_reg}, 1'b0};
        msg[1] = '{{1'b0, 7'(base_reg + 7'(knob))}, 1'b0};
        msg[2] = '{{1'b0, val}, 1'b1};
        return 3;
    endfunction

    // Offer one sample, wait for the beat, then book its expected bytes
    task automatic send_sample(input sample_row_t row);
        midi_beat_t msg [3];
        int         n;
        while (!steady_flow && $urandom_range(99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, row.rdy, row.smp, row.knob};
        do
            @(posedge clk);
        while (!s_axis_tready);
        n = predict_cc(row.knob, row.smp, row.rdy, msg);
        if (row.typed)
        begin
            if (row.n_exp == 2'd3)
            begin
                midi_expect_q.push_back('{row.st, 1'b0});
                midi_expect_q.push_back('{{1'b0, row.ctl}, 1'b0});
                midi_expect_q.push_back('{{1'b0, row.val}, 1'b1});
            end
        end
        else
        begin
            for (int k = 0; k < n; k++)
                midi_expect_q.push_back(msg[k]);
        end
        @(negedge clk);
    endtask

    // Write both registers back to back, block idle
    task automatic write_regs(input logic [3:0] chan, input logic [6:0] base);
        cfg_we    <= 1'b1;
        cfg_index <= skmc_pkg::CFG_MIDI_CHANNEL;
        cfg_wdata <= {3'd0, chan};
        @(negedge clk);
        cfg_index <= skmc_pkg::CFG_CONTROLLER_BASE;
        cfg_wdata <= base;
        @(negedge clk);
        cfg_we    <= 1'b0;
        chan_reg  = chan;
        base_reg  = base;
        @(negedge clk);
    endtask

    // Stop offering until all bytes are out and the pipeline is quiet
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (midi_expect_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        @(negedge clk);
    endtask

    // Random samples: drifting, repeated and extreme levels, some out-of-range knobs
    task automatic run_random(input int n_items);
        sample_row_t row;
        int          counted;
        int          mode;
        int          s;
        counted = 0;
        while (counted < n_items)
        begin
            row      = '0;
            row.knob = ($urandom_range(11) == 0) ? 2'd3 : 2'($urandom_range(2));
            row.rdy  = ($urandom_range(4) != 0);
            mode     = $urandom_range(9);
            if (mode <= 4)
                row.smp = 12'($urandom);
            else if (mode <= 7)
            begin
                s = int'(last_smp[row.knob]) + $urandom_range(128) - 64;
                row.smp = (s < 0) ? 12'd0 : (s > 4095) ? 12'd4095 : 12'(s);
            end
            else if (mode == 8)
                row.smp = last_smp[row.knob];
            else
                row.smp = $urandom_range(1) ? 12'd4095 : 12'd0;
            last_smp[row.knob] = row.smp;
            send_sample(row);
            if (row.knob < NUM_KNOBS)
                counted++;
        end
    endtask

    // Output checker
    always @(posedge clk)
    begin
        midi_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_seen++;
            if (midi_expect_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got data %02h last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = midi_expect_q.pop_front();
                if (want.data !== m_axis_tdata || want.last !== m_axis_tlast)
                begin
                    $display("%0t: beat mismatch, expected data %02h last %0b,",
                             $time, want.data, want.last,
                             " got data %02h last %0b", m_axis_tdata, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off
    initial
    begin
        int  stall_left;
        bit  stall_done;
        stall_left    = 0;
        stall_done    = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!stall_done && beats_seen >= 60)
            begin
                stall_done = 1'b1;
                stall_left = 300;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= steady_flow || ($urandom_range(99) >= 16);
        end
    end

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = skmc_pkg::CFG_MIDI_CHANNEL;
        cfg_wdata     = '0;
        errors        = 0;
        beats_seen    = 0;
        steady_flow   = 1'b0;
        chan_reg      = 4'd0;
        base_reg      = 7'd1;
        for (int k = 0; k < NUM_KNOBS; k++)
        begin
            level_mem[k] = '0;
            prev_val[k]  = '0;
        end
        for (int k = 0; k < 4; k++)
            last_smp[k] = '0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows with reset register values
        foreach (DIRECTED_ROWS[i])
            send_sample(DIRECTED_ROWS[i]);
        wait_drained();

        // Top channel and base, controller numbers wrap
        write_regs(4'd15, 7'd127);
        run_random(95);
        wait_drained();

        // Zero channel and base, no idling on either side
        write_regs(4'd0, 7'd0);
        steady_flow = 1'b1;
        run_random(95);
        wait_drained();
        steady_flow = 1'b0;

        // Arbitrary setting
        write_regs(4'($urandom_range(15)), 7'($urandom_range(127)));
        run_random(95);
        wait_drained();

        if (errors == 0 && midi_expect_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
